/* rtl/xcfr_pkg.sv */
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants for the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int OUT_DATA_W   = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NODE_ADDR  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_MARK = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN    = 2'd2;

    localparam logic [BYTE_W-1:0] NODE_ADDR_RST  = 8'd69;
    localparam logic [BYTE_W-1:0] START_MARK_RST = 8'd94;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 6'd20;

    typedef enum logic [3:0] {
        S_START1,
        S_START2,
        S_DEST,
        S_FLAGS,
        S_HDR,
        S_LEN,
        S_DATA,
        S_SUM,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic ld_dest;
        logic ld_flags;
        logic ld_len;
        logic ld_data;
        logic drain_ld;
    } t_cmd;

    typedef struct packed {
        logic start_hit;
        logic hdr_ok;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic sum_ok;
        logic out_free;
        logic drain_last;
    } t_status;

endpackage

`default_nettype wire

/* rtl/xor_checked_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_core
// Deframes start/start/dest/flags/hdr-check/length/payload/check frames and
// streams out the payload of good frames addressed to this node.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle on the slave stream. After the
// payload check byte of a frame that passes both XOR checks and matches
// node_address, the slave side stalls while the buffered payload drains
// from the output register: one beat per cycle while the master side is
// ready, L beats for an L-byte payload and a single marker beat (tuser low)
// for an empty one. The drain rate is set by the single output register
// read from the 32-entry payload buffer. Dropped or foreign frames never
// stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver_core
    import xcfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [BYTE_W-1:0]     i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [7:0] payload_byte, [12:8] byte_index, [18:13] frame_length,
    // [26:19] frame_flags, [31:27] zero
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tuser,   // [0] byte_valid
    output logic                       o_m_tlast
);

    t_cmd              w_cmd;
    t_status           w_status;
    logic [BYTE_W-1:0] w_payload_byte;
    logic [ADDR_W-1:0] w_byte_index;
    logic [LEN_W-1:0]  w_frame_length;
    logic [BYTE_W-1:0] w_frame_flags;

    xcfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    xcfr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (i_s_tdata),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_payload_byte (w_payload_byte),
        .o_byte_valid   (o_m_tuser),
        .o_byte_index   (w_byte_index),
        .o_frame_length (w_frame_length),
        .o_frame_flags  (w_frame_flags),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {5'b0, w_frame_flags, w_frame_length, w_byte_index, w_payload_byte};

    // drain only happens with the input side held off
    a_drain_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drain_ld |-> !o_s_tready)
        else $error("drain while input accepted");

    // the final beat of a frame releases the input side
    a_last_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.drain_ld && w_status.drain_last) |=> o_s_tready)
        else $error("input not released after final beat");

    // at most one datapath action per cycle
    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.ld_dest, w_cmd.ld_flags, w_cmd.ld_len, w_cmd.ld_data,
                  w_cmd.drain_ld}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

/* rtl/xcfr_ctrl.sv */
// ----------------------------------------------------------------------------
// xcfr_ctrl
// Frame state machine: walks the frame fields and sequences the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_ctrl
    import xcfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = (r_state != S_DRAIN);
    assign w_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START1;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_START1: if (w_acc && i_status.start_hit) n_state = S_START2;
            S_START2: begin
                // a wrong second byte is not retried as a first start byte
                if (w_acc) n_state = i_status.start_hit ? S_DEST : S_START1;
            end
            S_DEST:   if (w_acc) n_state = S_FLAGS;
            S_FLAGS:  if (w_acc) n_state = S_HDR;
            S_HDR:    if (w_acc) n_state = i_status.hdr_ok ? S_LEN : S_START1;
            S_LEN: begin
                if (w_acc) begin
                    if (!i_status.len_ok)       n_state = S_START1;
                    else if (i_status.len_zero) n_state = S_SUM;
                    else                        n_state = S_DATA;
                end
            end
            S_DATA:   if (w_acc && i_status.data_done) n_state = S_SUM;
            S_SUM:    if (w_acc) n_state = i_status.sum_ok ? S_DRAIN : S_START1;
            S_DRAIN:  if (i_status.out_free && i_status.drain_last) n_state = S_START1;
            default:  n_state = S_START1;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        case (r_state)
            S_DEST:  o_cmd.ld_dest  = w_acc;
            S_FLAGS: o_cmd.ld_flags = w_acc;
            S_LEN:   o_cmd.ld_len   = w_acc && i_status.len_ok;
            S_DATA:  o_cmd.ld_data  = w_acc;
            S_DRAIN: o_cmd.drain_ld = i_status.out_free;
            default: o_cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/xcfr_dpath.sv */
// ----------------------------------------------------------------------------
// xcfr_dpath
// Datapath: config registers, header fields, payload buffer, running XOR
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_dpath
    import xcfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [BYTE_W-1:0]     i_cfg_wdata,
    input  wire logic [BYTE_W-1:0]     i_rx_byte,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [BYTE_W-1:0]          o_payload_byte,
    output logic                       o_byte_valid,
    output logic [ADDR_W-1:0]          o_byte_index,
    output logic [LEN_W-1:0]           o_frame_length,
    output logic [BYTE_W-1:0]          o_frame_flags,
    output logic                       o_last
);

    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(BUFFER_DEPTH);

    logic [BYTE_W-1:0] r_node_addr;
    logic [BYTE_W-1:0] r_start_mark;
    logic [LEN_W-1:0]  r_max_len;
    logic [BYTE_W-1:0] r_dest;
    logic [BYTE_W-1:0] r_flags;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_xor;
    logic [ADDR_W-1:0] r_drain;
    logic [BYTE_W-1:0] r_store [BUFFER_DEPTH];

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bvalid;
    logic [ADDR_W-1:0] r_out_index;
    logic [LEN_W-1:0]  r_out_len;
    logic [BYTE_W-1:0] r_out_flags;
    logic              r_out_last;

    logic [LEN_W-1:0]  w_cap;
    logic [LEN_W-1:0]  w_pos_inc;
    logic [LEN_W-1:0]  w_drain_inc;
    logic              w_len_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr  <= NODE_ADDR_RST;
            r_start_mark <= START_MARK_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_NODE_ADDR:  r_node_addr  <= i_cfg_wdata;
                REG_START_MARK: r_start_mark <= i_cfg_wdata;
                REG_MAX_LEN:    r_max_len    <= i_cfg_wdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign w_cap       = (r_max_len > DEPTH_L) ? DEPTH_L : r_max_len;
    assign w_pos_inc   = r_pos + LEN_W'(1);
    assign w_drain_inc = {1'b0, r_drain} + LEN_W'(1);
    assign w_len_zero  = (r_len == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest  <= '0;
            r_flags <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_xor   <= '0;
            r_drain <= '0;
        end else begin
            if (i_cmd.ld_dest)  r_dest  <= i_rx_byte;
            if (i_cmd.ld_flags) r_flags <= i_rx_byte;
            if (i_cmd.ld_len) begin
                r_len   <= i_rx_byte[LEN_W-1:0];
                r_xor   <= i_rx_byte;
                r_pos   <= '0;
                r_drain <= '0;
            end
            if (i_cmd.ld_data) begin
                r_xor <= r_xor ^ i_rx_byte;
                r_pos <= w_pos_inc;
            end
            if (i_cmd.drain_ld) r_drain <= r_drain + ADDR_W'(1);
        end
    end

    // payload buffer; position never reaches the depth while writing
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_data) r_store[r_pos[ADDR_W-1:0]] <= i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.drain_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // empty payload gives one marker beat with zeroed byte and index
    always_ff @(posedge i_clk) begin
        if (i_cmd.drain_ld) begin
            r_out_byte   <= w_len_zero ? '0 : r_store[r_drain];
            r_out_bvalid <= !w_len_zero;
            r_out_index  <= w_len_zero ? '0 : r_drain;
            r_out_len    <= r_len;
            r_out_flags  <= r_flags;
            r_out_last   <= o_status.drain_last;
        end
    end

    always_comb begin
        o_status.start_hit  = (i_rx_byte == r_start_mark);
        o_status.hdr_ok     = ((r_dest ^ r_flags) == i_rx_byte);
        o_status.len_ok     = (i_rx_byte <= {{(BYTE_W-LEN_W){1'b0}}, w_cap});
        o_status.len_zero   = (i_rx_byte == '0);
        o_status.data_done  = (w_pos_inc >= r_len);
        o_status.sum_ok     = (r_dest == r_node_addr) && (r_xor == i_rx_byte);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.drain_last = w_len_zero || (w_drain_inc == r_len);
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_byte_valid   = r_out_bvalid;
    assign o_byte_index   = r_out_index;
    assign o_frame_length = r_out_len;
    assign o_frame_flags  = r_out_flags;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

/* bench/xcfr_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xcfr_frame_checker
// Watches the config port and both streams of the frame receiver, predicts the
// payload beats of every accepted frame and compares them as they leave.
// ----------------------------------------------------------------------------

module xcfr_frame_checker
    import xcfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [BYTE_W-1:0]     i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [7:0] payload_byte, [12:8] byte_index, [18:13] frame_length,
    // [26:19] frame_flags, [31:27] zero
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                  i_m_tuser,   // [0] byte_valid
    input  wire logic                  i_m_tlast,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic [4:0] idx;
        logic [5:0] len;
        logic [7:0] flags;
        logic       last;
    } t_beat;

    t_beat       payload_q[$];
    t_state      rx_phase;
    logic [7:0]  node_addr;
    logic [7:0]  start_mark;
    logic [5:0]  max_len;
    logic [7:0]  dest_byte;
    logic [7:0]  flags_byte;
    logic [7:0]  run_xor;
    logic [5:0]  frame_len;
    int          pos;
    logic [7:0]  frame_buf [BUFFER_DEPTH];
    int          fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic deframe_byte(input logic [7:0] b);
        int    cap;
        int    i;
        t_beat bt;
        cap = (int'(max_len) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(max_len);
        case (rx_phase)
            S_START1: begin
                if (b == start_mark) begin
                    rx_phase = S_START2;
                    pos      = 0;
                end
            end
            S_START2: rx_phase = (b == start_mark) ? S_DEST : S_START1;
            S_DEST: begin
                dest_byte = b;
                rx_phase  = S_FLAGS;
            end
            S_FLAGS: begin
                flags_byte = b;
                rx_phase   = S_HDR;
            end
            S_HDR: rx_phase = ((dest_byte ^ flags_byte) == b) ? S_LEN : S_START1;
            S_LEN: begin
                if (int'(b) > cap) begin
                    rx_phase = S_START1;
                end else begin
                    frame_len = b[5:0];
                    run_xor   = b;
                    pos       = 0;
                    rx_phase  = (b == 8'd0) ? S_SUM : S_DATA;
                end
            end
            S_DATA: begin
                if (pos < BUFFER_DEPTH)
                    frame_buf[pos] = b;
                run_xor = run_xor ^ b;
                pos++;
                if (pos >= int'(frame_len))
                    rx_phase = S_SUM;
            end
            default: begin
                if (dest_byte == node_addr && run_xor == b) begin
                    bt.len   = frame_len;
                    bt.flags = flags_byte;
                    if (frame_len == 6'd0) begin
                        // empty payload: one marker beat
                        bt.data = 8'd0;
                        bt.vld  = 1'b0;
                        bt.idx  = 5'd0;
                        bt.last = 1'b1;
                        payload_q.push_back(bt);
                    end else begin
                        for (i = 0; i < int'(frame_len) && i < BUFFER_DEPTH; i++) begin
                            bt.data = frame_buf[i];
                            bt.vld  = 1'b1;
                            bt.idx  = 5'(i);
                            bt.last = (i + 1 == int'(frame_len));
                            payload_q.push_back(bt);
                        end
                    end
                end
                rx_phase = S_START1;
            end
        endcase
    endtask

    task automatic report_beat(input string what, input t_beat want, input t_beat got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t %s: exp data=%02h vld=%0d idx=%0d len=%0d flags=%02h last=%0d | got data=%02h vld=%0d idx=%0d len=%0d flags=%02h last=%0d",
                     $realtime, what, want.data, want.vld, want.idx, want.len, want.flags,
                     want.last, got.data, got.vld, got.idx, got.len, got.flags, got.last);
    endtask

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            node_addr  = NODE_ADDR_RST;
            start_mark = START_MARK_RST;
            max_len    = MAX_LEN_RST;
            rx_phase   = S_START1;
            dest_byte  = 8'd0;
            flags_byte = 8'd0;
            frame_len  = 6'd0;
            run_xor    = 8'd0;
            pos        = 0;
            payload_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_NODE_ADDR:  node_addr  = i_cfg_wdata;
                    REG_START_MARK: start_mark = i_cfg_wdata;
                    REG_MAX_LEN:    max_len    = i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                deframe_byte(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got.data  = i_m_tdata[7:0];
                got.vld   = i_m_tuser;
                got.idx   = i_m_tdata[12:8];
                got.len   = i_m_tdata[18:13];
                got.flags = i_m_tdata[26:19];
                got.last  = i_m_tlast;
                if (payload_q.size() == 0) begin
                    report_beat("unexpected beat", '0, got);
                end else begin
                    want = payload_q.pop_front();
                    if (got != want)
                        report_beat("beat mismatch", want, got);
                end
            end
        end
        o_pending <= payload_q.size();
    end

endmodule

/* bench/tb_xor_checked_frame_receiver_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_checked_frame_receiver_core
// Drives framed byte traffic (good, corrupt, foreign and truncated frames plus
// line noise) into the receiver under several register settings, with random
// stalls on both streams; the checker scores the payload stream.
// ----------------------------------------------------------------------------

module tb_xor_checked_frame_receiver_core;
    import xcfr_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 48;
    localparam int PHASE_BYTES     = 28;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        FR_GOOD,
        FR_BAD_START2,
        FR_BAD_HDR,
        FR_BAD_LEN,
        FR_BAD_SUM
    } t_frame_fault;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    pending;

    // stimulus-side copy of the registers, for building frames only
    logic [7:0] node_addr  = NODE_ADDR_RST;
    logic [7:0] start_mark = START_MARK_RST;
    logic [5:0] max_len    = MAX_LEN_RST;

    logic s_idle_on     = 1'b0;
    logic m_idle_on     = 1'b0;
    logic hold_off_req  = 1'b0;
    int   bytes_sent    = 0;
    int   quiet_cycles  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xor_checked_frame_receiver_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    xcfr_frame_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // payload sink: random stall bursts, plus one long hold-off on request
    always begin : sink_ready
        int burst;
        @(posedge clk);
        if (hold_off_req) begin
            m_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off_req = 1'b0;
            m_tready <= 1'b1;
        end else if (m_idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 6);
            m_tready <= 1'b0;
            repeat (burst) @(posedge clk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int len_cap();
        return (int'(max_len) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(max_len);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (s_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // fill < 0 gives random payload bytes
    task automatic send_frame(input logic [7:0] dest, input logic [7:0] flags, input int len,
                              input t_frame_fault fault, input int fill);
        logic [7:0] chk;
        logic [7:0] b;
        logic [7:0] flip;
        int         i;
        flip = 8'($urandom_range(1, 255));
        send_byte(start_mark);
        if (fault == FR_BAD_START2) begin
            send_byte(start_mark ^ flip);
            return;
        end
        send_byte(start_mark);
        send_byte(dest);
        send_byte(flags);
        if (fault == FR_BAD_HDR) begin
            send_byte(dest ^ flags ^ flip);
            return;
        end
        send_byte(dest ^ flags);
        if (fault == FR_BAD_LEN) begin
            send_byte(8'($urandom_range(len_cap() + 1, 255)));
            return;
        end
        send_byte(8'(len));
        chk = 8'(len);
        for (i = 0; i < len; i++) begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            chk = chk ^ b;
            send_byte(b);
        end
        send_byte((fault == FR_BAD_SUM) ? (chk ^ flip) : chk);
    endtask

    task automatic set_config(input logic [7:0] node, input logic [7:0] start,
                              input logic [7:0] maxlen);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_NODE_ADDR;
        cfg_wdata <= node;
        @(posedge clk);
        cfg_addr  <= REG_START_MARK;
        cfg_wdata <= start;
        @(posedge clk);
        cfg_addr  <= REG_MAX_LEN;
        cfg_wdata <= maxlen;
        @(posedge clk);
        // unmapped index, must change nothing
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= 8'($urandom);
        @(posedge clk);
        cfg_we     <= 1'b0;
        node_addr  = node;
        start_mark = start;
        max_len    = maxlen[5:0];
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_traffic(input int stop_at, input logic idle_phase);
        int           pick;
        int           cap;
        int           len;
        int           r;
        t_frame_fault fault;
        logic [7:0]   dest;
        while (bytes_sent < stop_at) begin
            s_idle_on = idle_phase && ($urandom_range(0, 3) != 0);
            m_idle_on = idle_phase && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            cap  = len_cap();
            if (pick < 12) begin
                send_byte(8'($urandom));
            end else if (pick < 18) begin
                // broken-off frame: the next frame may get swallowed as its body
                send_byte(start_mark);
                send_byte(start_mark);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
            end else begin
                dest = ($urandom_range(0, 3) != 0) ? node_addr : 8'($urandom);
                r    = $urandom_range(0, 9);
                if (r == 0)
                    len = cap;
                else if (r < 7)
                    len = $urandom_range(0, (cap < 6) ? cap : 6);
                else
                    len = $urandom_range(0, cap);
                r = $urandom_range(0, 9);
                case (r)
                    6:       fault = FR_BAD_START2;
                    7:       fault = FR_BAD_HDR;
                    8:       fault = FR_BAD_LEN;
                    9:       fault = FR_BAD_SUM;
                    default: fault = FR_GOOD;
                endcase
                send_frame(dest, 8'($urandom), len, fault, -1);
            end
        end
    endtask

    initial begin
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_frame(node_addr, 8'hFF, 0, FR_GOOD, 0);
        send_frame(node_addr, 8'h00, 1, FR_GOOD, 8'hFF);
        send_frame(node_addr, 8'h5A, 1, FR_BAD_START2, 0);
        send_frame(node_addr, 8'h33, 1, FR_BAD_HDR, 0);
        send_frame(node_addr, 8'h11, 1, FR_BAD_LEN, 0);
        send_frame(node_addr, 8'h22, 1, FR_BAD_SUM, 8'h00);
        send_frame(node_addr ^ 8'h01, 8'h44, 0, FR_GOOD, 0);
        random_traffic(bytes_sent + PHASE_BYTES, 1'b1);
        wait_drained();

        // low extremes: only empty frames fit
        set_config(8'h00, 8'h00, 8'd0);
        send_frame(8'h00, 8'h80, 0, FR_GOOD, 0);
        send_frame(8'h00, 8'h01, 1, FR_GOOD, 8'h00);
        random_traffic(bytes_sent + PHASE_BYTES, 1'b1);
        wait_drained();

        // high extremes: length field wider than the buffer, cap is the buffer
        set_config(8'hFF, 8'hFF, 8'd63);
        send_frame(8'hFF, 8'hFF, BUFFER_DEPTH, FR_GOOD, -1);
        send_frame(8'hFF, 8'h00, BUFFER_DEPTH, FR_BAD_LEN, 0);
        random_traffic(bytes_sent + PHASE_BYTES, 1'b1);
        wait_drained();

        // sink holds off while good frames keep arriving
        set_config(8'($urandom), 8'($urandom), 8'd32);
        hold_off_req = 1'b1;
        for (i = 0; i < 4; i++)
            send_frame(node_addr, 8'($urandom), $urandom_range(4, 16), FR_GOOD, -1);
        random_traffic(bytes_sent + PHASE_BYTES, 1'b1);
        wait_drained();

        set_config(8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(bytes_sent + PHASE_BYTES, 1'b1);
        wait_drained();

        // closing stretch without stalls
        set_config(8'($urandom), 8'($urandom), 8'($urandom_range(1, 32)));
        random_traffic(bytes_sent + PHASE_BYTES, 1'b0);
        wait_drained();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/xcfr_pkg.sv
rtl/xcfr_ctrl.sv
rtl/xcfr_dpath.sv
rtl/xor_checked_frame_receiver_core.sv
bench/xcfr_frame_checker.sv
bench/tb_xor_checked_frame_receiver_core.sv
